[src/rmsp_pkg.sv]
// Shared types and constants of the RMSProp weight update block.
`timescale 1ns / 1ps
package rmsp_pkg;

    localparam int IDX_W     = 12;
    localparam int DATA_W    = 32;
    localparam int RAD_W     = 48;
    localparam int ROOT_W    = 24;
    localparam int SQ_REM_W  = 28;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 25;
    localparam int DIV_REM_W = 26;
    localparam int PADDR_W   = 4;

    localparam logic [1:0] REG_DECAY = 2'd0;
    localparam logic [1:0] REG_EPS   = 2'd1;
    localparam logic [1:0] REG_LR    = 2'd2;
    localparam logic [1:0] REG_BATCH = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0]         element_index;
        logic signed [DATA_W-1:0] gradient;
        logic signed [DATA_W-1:0] weight;
        logic                     apply_batch;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0]         result_index;
        logic signed [DATA_W-1:0] new_weight;
        logic                     weight_changed;
    } t_out_beat;

    // Per-item context that travels down the pipeline.
    typedef struct packed {
        logic                     valid;
        logic                     inrange;
        logic                     neg;
        logic                     apply;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] w;
        logic [DATA_W-1:0]        mag;
    } t_ctx;

endpackage

[src/rmsp_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module rmsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/rmsp_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmsp_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  rmsp_pkg::t_ctx              i_ctx,
    input  logic [rmsp_pkg::RAD_W-1:0]  i_rad,
    output rmsp_pkg::t_ctx              o_ctx,
    output logic [rmsp_pkg::ROOT_W-1:0] o_root
);

    localparam int N  = rmsp_pkg::ROOT_W;
    localparam int RW = rmsp_pkg::SQ_REM_W;

    rmsp_pkg::t_ctx               r_ctx  [0:N-1];
    logic [rmsp_pkg::RAD_W-1:0]   r_rad  [0:N-1];
    logic [N-1:0]                 r_root [0:N-1];
    logic [RW-1:0]                r_rem  [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            rmsp_pkg::t_ctx             c_ctx;
            logic [rmsp_pkg::RAD_W-1:0] c_rad;
            logic [N-1:0]               c_root;
            logic [RW-1:0]              c_rem;
            logic [RW-1:0]              rem_sh;
            logic [RW-1:0]              trial;
            logic [RW-1:0]              n_rem;
            logic [N-1:0]               n_root;

            if (k == 0) begin : g_first
                assign c_ctx  = i_ctx;
                assign c_rad  = i_rad;
                assign c_root = '0;
                assign c_rem  = '0;
            end else begin : g_next
                assign c_ctx  = r_ctx[k-1];
                assign c_rad  = r_rad[k-1];
                assign c_root = r_root[k-1];
                assign c_rem  = r_rem[k-1];
            end

            // Bring down the next pair of radicand bits and try the next root bit.
            always_comb begin
                rem_sh = {c_rem[RW-3:0], c_rad[rmsp_pkg::RAD_W-1 -: 2]};
                trial  = RW'({c_root, 2'b01});
                if (rem_sh >= trial) begin
                    n_rem  = rem_sh - trial;
                    n_root = {c_root[N-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_root = {c_root[N-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctx[k].valid <= 1'b0;
                end else if (i_en) begin
                    r_ctx[k] <= c_ctx;
                end
                if (i_en) begin
                    r_rad[k]  <= {c_rad[rmsp_pkg::RAD_W-3:0], 2'b00};
                    r_root[k] <= n_root;
                    r_rem[k]  <= n_rem;
                end
            end
        end
    endgenerate

    assign o_ctx  = r_ctx[N-1];
    assign o_root = r_root[N-1];

endmodule

[src/rmsp_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rmsp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  rmsp_pkg::t_ctx             i_ctx,
    input  logic [rmsp_pkg::NUM_W-1:0] i_num,
    input  logic [rmsp_pkg::DEN_W-1:0] i_den,
    output rmsp_pkg::t_ctx             o_ctx,
    output logic [rmsp_pkg::NUM_W-1:0] o_quo
);

    localparam int N  = rmsp_pkg::NUM_W;
    localparam int RW = rmsp_pkg::DIV_REM_W;

    rmsp_pkg::t_ctx             r_ctx [0:N-1];
    logic [N-1:0]               r_num [0:N-1];
    logic [rmsp_pkg::DEN_W-1:0] r_den [0:N-1];
    logic [RW-1:0]              r_rem [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            rmsp_pkg::t_ctx             c_ctx;
            logic [N-1:0]               c_num;
            logic [rmsp_pkg::DEN_W-1:0] c_den;
            logic [RW-1:0]              c_rem;
            logic [RW-1:0]              rem_sh;
            logic [RW-1:0]              den_x;
            logic [RW-1:0]              n_rem;
            logic                       qbit;

            if (k == 0) begin : g_first
                assign c_ctx = i_ctx;
                assign c_num = i_num;
                assign c_den = i_den;
                assign c_rem = '0;
            end else begin : g_next
                assign c_ctx = r_ctx[k-1];
                assign c_num = r_num[k-1];
                assign c_den = r_den[k-1];
                assign c_rem = r_rem[k-1];
            end

            // Shift in the next dividend bit; quotient bits fill the dividend from below.
            always_comb begin
                rem_sh = {c_rem[RW-2:0], c_num[N-1]};
                den_x  = RW'(c_den);
                if (rem_sh >= den_x) begin
                    n_rem = rem_sh - den_x;
                    qbit  = 1'b1;
                end else begin
                    n_rem = rem_sh;
                    qbit  = 1'b0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctx[k].valid <= 1'b0;
                end else if (i_en) begin
                    r_ctx[k] <= c_ctx;
                end
                if (i_en) begin
                    r_num[k] <= {c_num[N-2:0], qbit};
                    r_den[k] <= c_den;
                    r_rem[k] <= n_rem;
                end
            end
        end
    endgenerate

    assign o_ctx = r_ctx[N-1];
    assign o_quo = r_num[N-1];

endmodule

[src/rmsprop_weight_update.sv]
// RMSProp weight update: one weight element in, one updated weight out per beat.
`timescale 1ns / 1ps
// One beat is taken per clock while o_in_stall is low, and each beat yields
// exactly one result beat, in order. Most of the depth is the pipelined square
// root (24 stages, one root bit each) and the pipelined divider (48 stages, one
// quotient bit each). The mean square cache and the step accumulator each live
// in a RAM of ELEMENTS words with registered read. The cache is read as the
// beat is accepted and rewritten as the beat leaves the first stage register;
// the accumulator is read and rewritten at the tail of the pipeline. A one-deep
// bypass on each RAM covers an element that comes back in the very next beat,
// so repeated indices run at full rate. After reset both RAMs are cleared by a
// sweep over all ELEMENTS words, one word a cycle; input is stalled during the
// sweep, configuration writes go through. A stall on a waiting output beat
// freezes the whole pipeline; the output register keeps its beat and the input
// stalls until that beat is taken. An element index at or above ELEMENTS leaves
// both stores alone and returns the weight unchanged.
module rmsprop_weight_update #(
    parameter int ELEMENTS = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rmsp_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rmsp_pkg::t_out_beat                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rmsp_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    // ---------------- configuration registers ----------------
    logic [15:0] r_decay;
    logic [15:0] r_eps;
    logic [15:0] r_lr;
    logic [10:0] r_batch;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= 16'd58982;
            r_eps   <= 16'd1;
            r_lr    <= 16'd655;
            r_batch <= 11'd1;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                rmsp_pkg::REG_DECAY: r_decay <= pwdata[15:0];
                rmsp_pkg::REG_EPS:   r_eps   <= pwdata[15:0];
                rmsp_pkg::REG_LR:    r_lr    <= pwdata[15:0];
                rmsp_pkg::REG_BATCH: r_batch <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            rmsp_pkg::REG_DECAY: prdata = {16'd0, r_decay};
            rmsp_pkg::REG_EPS:   prdata = {16'd0, r_eps};
            rmsp_pkg::REG_LR:    prdata = {16'd0, r_lr};
            rmsp_pkg::REG_BATCH: prdata = {21'd0, r_batch};
            default:             prdata = '0;
        endcase
    end

    // ---------------- clearing sweep and pipeline advance ----------------
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_out_valid;
    logic          adv;
    logic          accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(ELEMENTS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // The whole pipeline moves as one; it holds only while the output beat waits.
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clearing || !adv;
    assign accept     = i_in_valid && !o_in_stall;

    // ---------------- input stage: magnitude and square ----------------
    logic [31:0]   in_mag;
    logic [63:0]   in_sq_full;
    logic [AW-1:0] in_addr;
    logic          in_range;

    assign in_mag     = i_in_data.gradient[31] ? 32'(-i_in_data.gradient)
                                               : 32'(i_in_data.gradient);
    assign in_sq_full = 64'(in_mag) * 64'(in_mag);
    assign in_addr    = AW'(i_in_data.element_index);
    assign in_range   = (32'(i_in_data.element_index) < 32'(ELEMENTS));

    rmsp_pkg::t_ctx r_s1_ctx;
    logic [31:0]    r_s1_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctx.valid <= 1'b0;
        end else if (adv) begin
            r_s1_ctx.valid <= accept;
        end
        if (adv) begin
            r_s1_ctx.inrange <= in_range;
            r_s1_ctx.neg     <= i_in_data.gradient[31];
            r_s1_ctx.apply   <= i_in_data.apply_batch;
            r_s1_ctx.idx     <= i_in_data.element_index;
            r_s1_ctx.w       <= i_in_data.weight;
            r_s1_ctx.mag     <= in_mag;
            r_s1_sq          <= in_sq_full[63:32];
        end
    end

    // ---------------- cache read-modify-write ----------------
    logic [31:0]    cache_rdata;
    logic [31:0]    cache_cur;
    logic [16:0]    decay_c;
    logic [49:0]    mix_sum;
    logic [31:0]    mixed;
    logic           cache_upd;
    logic           cache_we;
    logic [AW-1:0]  cache_waddr;
    logic [31:0]    cache_wdata;
    rmsp_pkg::t_ctx r_s2_ctx;
    logic [31:0]    r_s2_mixed;

    // Bypass the word that the previous beat wrote as it left the first stage.
    assign cache_cur = (r_s2_ctx.valid && r_s2_ctx.inrange && r_s1_ctx.inrange
                        && (r_s2_ctx.idx == r_s1_ctx.idx)) ? r_s2_mixed : cache_rdata;
    assign decay_c   = 17'h1_0000 - {1'b0, r_decay};
    // A convex mix of two 32-bit values, so bits above 47 stay clear.
    assign mix_sum   = 50'(r_decay) * 50'(cache_cur) + 50'(decay_c) * 50'(r_s1_sq);
    assign mixed     = mix_sum[47:16];

    assign cache_upd   = adv && r_s1_ctx.valid && r_s1_ctx.inrange;
    assign cache_we    = r_clearing || cache_upd;
    assign cache_waddr = r_clearing ? r_clr_addr : AW'(r_s1_ctx.idx);
    assign cache_wdata = r_clearing ? 32'd0 : mixed;

    rmsp_ram #(
        .WIDTH (32),
        .DEPTH (ELEMENTS)
    ) u_cache_ram (
        .i_clk   (i_clk),
        .i_we    (cache_we),
        .i_waddr (cache_waddr),
        .i_wdata (cache_wdata),
        .i_re    (adv),
        .i_raddr (in_addr),
        .o_rdata (cache_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctx.valid <= 1'b0;
        end else if (adv) begin
            r_s2_ctx <= r_s1_ctx;
        end
        if (adv) begin
            r_s2_mixed <= mixed;
        end
    end

    // ---------------- root of the new cache ----------------
    rmsp_pkg::t_ctx              sq_ctx;
    logic [rmsp_pkg::ROOT_W-1:0] sq_root;

    rmsp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctx   (r_s2_ctx),
        .i_rad   ({r_s2_mixed, 16'h0000}),
        .o_ctx   (sq_ctx),
        .o_root  (sq_root)
    );

    // ---------------- denominator and numerator ----------------
    logic [rmsp_pkg::DEN_W-1:0] den_sum;
    logic [rmsp_pkg::DEN_W-1:0] den_fix;
    rmsp_pkg::t_ctx             r_dn_ctx;
    logic [rmsp_pkg::DEN_W-1:0] r_dn_den;
    logic [rmsp_pkg::NUM_W-1:0] r_dn_num;

    assign den_sum = rmsp_pkg::DEN_W'(sq_root) + rmsp_pkg::DEN_W'(r_eps);
    // Zero root with zero epsilon divides by one.
    assign den_fix = (den_sum == '0) ? rmsp_pkg::DEN_W'(1) : den_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dn_ctx.valid <= 1'b0;
        end else if (adv) begin
            r_dn_ctx <= sq_ctx;
        end
        if (adv) begin
            r_dn_den <= den_fix;
            r_dn_num <= rmsp_pkg::NUM_W'(r_lr) * rmsp_pkg::NUM_W'(sq_ctx.mag);
        end
    end

    // ---------------- step quotient ----------------
    rmsp_pkg::t_ctx             dv_ctx;
    logic [rmsp_pkg::NUM_W-1:0] dv_quo;

    rmsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctx   (r_dn_ctx),
        .i_num   (r_dn_num),
        .i_den   (r_dn_den),
        .o_ctx   (dv_ctx),
        .o_quo   (dv_quo)
    );

    logic signed [31:0] step_sat;
    rmsp_pkg::t_ctx     r_st_ctx;
    logic signed [31:0] r_st_step;

    always_comb begin
        if (dv_ctx.neg) begin
            step_sat = (dv_quo > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                     : 32'(-dv_quo[31:0]);
        end else begin
            step_sat = (dv_quo > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                     : 32'(dv_quo[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_ctx.valid <= 1'b0;
        end else if (adv) begin
            r_st_ctx <= dv_ctx;
        end
        if (adv) begin
            r_st_step <= step_sat;
        end
    end

    // ---------------- accumulator read-modify-write and result ----------------
    logic [31:0]         acc_rdata;
    logic signed [31:0]  acc_cur;
    logic                single_mode;
    logic                e_we;
    logic signed [31:0]  e_acc_new;
    rmsp_pkg::t_out_beat e_out;
    logic                acc_we;
    logic [AW-1:0]       acc_waddr;
    logic [31:0]         acc_wdata;
    rmsp_pkg::t_ctx      r_e_ctx;
    logic signed [31:0]  r_e_step;
    logic                r_fw_valid;
    logic [rmsp_pkg::IDX_W-1:0] r_fw_idx;
    logic signed [31:0]  r_fw_data;
    rmsp_pkg::t_out_beat r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctx.valid <= 1'b0;
        end else if (adv) begin
            r_e_ctx <= r_st_ctx;
        end
        if (adv) begin
            r_e_step <= r_st_step;
        end
    end

    assign acc_cur     = (r_fw_valid && (r_fw_idx == r_e_ctx.idx)) ? r_fw_data
                                                                  : $signed(acc_rdata);
    assign single_mode = (r_batch <= 11'd1);

    always_comb begin
        e_we                 = 1'b0;
        e_acc_new            = acc_cur;
        e_out.result_index   = r_e_ctx.idx;
        e_out.new_weight     = r_e_ctx.w;
        e_out.weight_changed = 1'b0;
        if (r_e_ctx.valid && r_e_ctx.inrange) begin
            if (single_mode) begin
                e_out.new_weight     = sat_add(r_e_ctx.w, r_e_step);
                e_out.weight_changed = 1'b1;
            end else if (!r_e_ctx.apply) begin
                e_we      = 1'b1;
                e_acc_new = sat_add(acc_cur, r_e_step);
            end else begin
                // Apply: drop this beat's step, take the accumulated one, then clear.
                e_we                 = 1'b1;
                e_acc_new            = 32'sd0;
                e_out.new_weight     = sat_add(r_e_ctx.w, acc_cur);
                e_out.weight_changed = 1'b1;
            end
        end
    end

    assign acc_we    = r_clearing || (adv && e_we);
    assign acc_waddr = r_clearing ? r_clr_addr : AW'(r_e_ctx.idx);
    assign acc_wdata = r_clearing ? 32'd0 : 32'(e_acc_new);

    rmsp_ram #(
        .WIDTH (32),
        .DEPTH (ELEMENTS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_re    (adv),
        .i_raddr (AW'(r_st_ctx.idx)),
        .o_rdata (acc_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_fw_valid  <= e_we;
            r_out_valid <= r_e_ctx.valid;
        end
        if (adv) begin
            r_fw_idx   <= r_e_ctx.idx;
            r_fw_data  <= e_acc_new;
            r_out_data <= e_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------- assertions ----------------
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> o_in_stall)
        else $error("input accepted during RAM clearing sweep");

    a_out_of_range_untouched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_ctx.valid && !r_e_ctx.inrange) |-> (!e_we && !e_out.weight_changed))
        else $error("out-of-range element modified state or weight");

    a_single_mode_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_ctx.valid && r_e_ctx.inrange && single_mode)
            |-> (!e_we && e_out.weight_changed))
        else $error("single mode touched accumulator or kept weight");

    a_apply_clears_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && e_we && r_e_ctx.apply && !single_mode) |-> (acc_wdata == 32'd0))
        else $error("apply beat did not clear the accumulator");

endmodule

[tb/sv/rmsprop_update_checker.sv]
// Watches the ports of the RMSProp weight update block, predicts each result beat and compares it.
`timescale 1ns / 1ps
module rmsprop_update_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  rmsp_pkg::t_in_beat            i_in_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  rmsp_pkg::t_out_beat           i_out_data,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [rmsp_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [31:0]                   i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int N_ELEM = 4096;

    logic [31:0]         ms_cache [N_ELEM];
    logic [31:0]         step_acc [N_ELEM];
    logic [15:0]         cfg_decay;
    logic [15:0]         cfg_eps;
    logic [15:0]         cfg_lr;
    logic [10:0]         cfg_batch;
    rmsp_pkg::t_out_beat expected_weights [$];
    int                  fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_weights.size();

    // Bitwise integer square root, floor.
    function automatic logic [31:0] int_root(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (32'd1 << i);
            if ({32'd0, t} * {32'd0, t} <= v) r = t;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [33:0] s;
        s = 34'(a) + 34'(b);
        if (s > 34'sd2147483647) return 32'sh7fffffff;
        if (s < -34'sd2147483648) return 32'sh80000000;
        return s[31:0];
    endfunction

    // Advance the element's state and return the weight beat it produces.
    function automatic rmsp_pkg::t_out_beat rmsprop_step(input rmsp_pkg::t_in_beat b);
        rmsp_pkg::t_out_beat r;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] mixed;
        logic [63:0] denom;
        logic [63:0] q;
        logic signed [31:0] step;
        int          ix;
        ix  = b.element_index;
        mag = b.gradient[31] ? 64'(-65'(signed'(b.gradient))) : 64'(b.gradient);
        sq  = (mag * mag) >> 32;
        mixed = (64'(cfg_decay) * 64'(ms_cache[ix]) + (64'd65536 - 64'(cfg_decay)) * sq) >> 16;
        if (mixed > 64'hffffffff) mixed = 64'hffffffff;
        ms_cache[ix] = mixed[31:0];
        denom = 64'(int_root(mixed << 16)) + 64'(cfg_eps);
        if (denom == 0) denom = 1;
        q = (64'(cfg_lr) * mag) / denom;
        if (b.gradient[31]) step = (q > 64'h80000000) ? 32'sh80000000 : -32'(q);
        else                step = (q > 64'h7fffffff) ? 32'sh7fffffff : 32'(q);
        r.result_index = b.element_index;
        if (cfg_batch <= 1) begin
            r.new_weight     = sat_add(b.weight, step);
            r.weight_changed = 1'b1;
        end else if (!b.apply_batch) begin
            step_acc[ix]     = sat_add(step_acc[ix], step);
            r.new_weight     = b.weight;
            r.weight_changed = 1'b0;
        end else begin
            r.new_weight     = sat_add(b.weight, step_acc[ix]);
            step_acc[ix]     = '0;
            r.weight_changed = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        rmsp_pkg::t_out_beat e;
        if (!i_rst_n) begin
            for (int i = 0; i < N_ELEM; i++) begin
                ms_cache[i] = '0;
                step_acc[i] = '0;
            end
            cfg_decay = 16'd58982;
            cfg_eps   = 16'd1;
            cfg_lr    = 16'd655;
            cfg_batch = 11'd1;
            expected_weights.delete();
            fails = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    rmsp_pkg::REG_DECAY: cfg_decay = i_pwdata[15:0];
                    rmsp_pkg::REG_EPS:   cfg_eps   = i_pwdata[15:0];
                    rmsp_pkg::REG_LR:    cfg_lr    = i_pwdata[15:0];
                    rmsp_pkg::REG_BATCH: cfg_batch = i_pwdata[10:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) expected_weights.push_back(rmsprop_step(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (expected_weights.size() == 0) begin
                    $error("unexpected result beat index %0d", i_out_data.result_index);
                    fails++;
                end else begin
                    e = expected_weights.pop_front();
                    if (e.result_index !== i_out_data.result_index) begin
                        $error("result_index exp %0d got %0d", e.result_index,
                               i_out_data.result_index);
                        fails++;
                    end
                    if (e.new_weight !== i_out_data.new_weight) begin
                        $error("new_weight exp %h got %h", e.new_weight, i_out_data.new_weight);
                        fails++;
                    end
                    if (e.weight_changed !== i_out_data.weight_changed) begin
                        $error("weight_changed exp %b got %b", e.weight_changed,
                               i_out_data.weight_changed);
                        fails++;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/tb.sv]
// Top of the RMSProp weight update testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          in_valid;
    logic                          in_stall;
    rmsp_pkg::t_in_beat            in_data;
    logic                          out_valid;
    logic                          out_stall;
    rmsp_pkg::t_out_beat           out_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [rmsp_pkg::PADDR_W-1:0]  paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    int                            fail_count;
    int                            pending;

    // quiet: no idling on either side; hold_req: ask the sink for one long hold-off
    bit                            quiet;
    bit                            hold_req;
    logic [11:0]                   elem_pool [6];

    rmsprop_weight_update dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    rmsprop_update_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop: the slowest legal run (clear sweep, stalls, long hold-off) is far shorter.
    initial begin
        #400000;
        $display("[rmsprop_weight_update] ERROR");
        $finish;
    end

    // Sink side: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        out_stall = 1'b1;
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Setup cycle then access cycle; the register takes the value on the access edge.
    task automatic reg_write(input logic [1:0] reg_id, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rmsp_pkg::PADDR_W'({reg_id, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Offer one beat, with an optional idle burst first; return on the accept edge.
    task automatic send_beat(input logic [11:0] ix, input logic [31:0] g,
                             input logic [31:0] w, input logic ap);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid              <= 1'b1;
        in_data.element_index <= ix;
        in_data.gradient      <= g;
        in_data.weight        <= w;
        in_data.apply_batch   <= ap;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Drain every expected beat, then let the pipeline settle before touching registers.
    task automatic drain_and_config(input logic [15:0] dc, input logic [15:0] ep,
                                    input logic [15:0] lr, input logic [10:0] bs);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        reg_write(rmsp_pkg::REG_DECAY, 32'(dc));
        reg_write(rmsp_pkg::REG_EPS, 32'(ep));
        reg_write(rmsp_pkg::REG_LR, 32'(lr));
        reg_write(rmsp_pkg::REG_BATCH, 32'(bs));
    endtask

    function automatic logic [31:0] pick_gradient();
        case ($urandom_range(0, 4))
            0:       return $urandom();
            1:       return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            3:       return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            default: return '0;
        endcase
    endfunction

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 3))
            0:       return 32'h7fffffff - 32'($urandom_range(0, 255));
            1:       return 32'h80000000 + 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    // Random beats; batch phases draw from a small element pool so steps pile up
    // and get applied, single phases mix the pool with indices from the whole range.
    task automatic random_phase(input int n, input bit batched);
        logic [11:0] ix;
        for (int i = 0; i < 6; i++) elem_pool[i] = 12'($urandom());
        for (int i = 0; i < n; i++) begin
            if (batched || $urandom_range(0, 1)) ix = elem_pool[$urandom_range(0, 5)];
            else ix = 12'($urandom());
            send_beat(ix, pick_gradient(), pick_weight(),
                      batched ? ($urandom_range(0, 4) == 0) : 1'($urandom()));
        end
    endtask

    initial begin
        logic [15:0] rd;
        logic [15:0] re;
        logic [15:0] rl;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, single mode: field extremes and back-to-back repeats.
        send_beat(12'd0, 32'h7fffffff, 32'h7fffffff, 1'b0);
        send_beat(12'd0, 32'h80000000, 32'h80000000, 1'b1);
        send_beat(12'd0, 32'h80000000, 32'h7fffffff, 1'b0);
        send_beat(12'd4095, 32'h0, 32'h0, 1'b0);
        send_beat(12'd4095, 32'hffffffff, 32'hffffffff, 1'b1);
        send_beat(12'd5, 32'h01000000, 32'h80000000, 1'b0);
        send_beat(12'd5, 32'h01000000, 32'h0, 1'b0);
        send_beat(12'd5, 32'hff000000, 32'h0, 1'b0);
        random_phase(80, 1'b0);

        // Extreme rate and epsilon; long sink hold-off so the input backs up.
        drain_and_config(16'd0, 16'd65535, 16'd65535, 11'd1);
        hold_req = 1'b1;
        random_phase(90, 1'b0);

        // Batch of four: accumulate then apply, plus apply on an empty accumulator.
        drain_and_config(16'd65535, 16'd1, 16'd65535, 11'd4);
        send_beat(12'd7, 32'h01000000, 32'h0, 1'b0);
        send_beat(12'd7, 32'h7fffffff, 32'h0, 1'b0);
        send_beat(12'd7, 32'h00800000, 32'h0, 1'b0);
        send_beat(12'd7, 32'h0, 32'h7ffffff0, 1'b1);
        send_beat(12'd9, 32'h80000000, 32'h80000000, 1'b1);
        random_phase(90, 1'b1);

        // Zero epsilon with zero root, batch size zero behaves as single mode.
        drain_and_config(16'd0, 16'd0, 16'd1000, 11'd0);
        send_beat(12'd4000, 32'h0, 32'h12345678, 1'b0);
        send_beat(12'd4000, 32'h0, 32'h12345678, 1'b1);
        random_phase(80, 1'b0);

        drain_and_config(16'd30000, 16'd300, 16'd20000, 11'd1024);
        random_phase(90, 1'b1);

        drain_and_config(16'd65535, 16'd65535, 16'd0, 11'd2);
        random_phase(80, 1'b1);

        rd = 16'($urandom());
        re = 16'($urandom_range(1, 65535));
        rl = 16'($urandom());
        drain_and_config(rd, re, rl, 11'd3);
        random_phase(60, 1'b1);

        // Last stretch at full rate on both sides.
        quiet = 1'b1;
        random_phase(60, 1'b1);

        in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[rmsprop_weight_update] OK");
        end else begin
            $display("[rmsprop_weight_update] ERROR");
        end
        $finish;
    end

endmodule
